@@ rtl/core/tsmf_pkg.sv @@
// Shared constants and command types for the five-tap smoothing filter.
package tsmf_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int QDEPTH_DEF      = 4;

  // Command handed from the front to the back: how many results to emit
  // and whether the last of them closes the record.
  typedef struct packed {
    logic [1:0] cnt;
    logic       eor;
  } cmd_ctl_t;

endpackage

@@ rtl/core/five_tap_weighted_smoothing_filter.sv @@
// Top level of the five-tap 1-2-3-2-1 weighted smoothing filter.
//
// Input side is a queue write port: a transaction happens on a clock edge
// with in_push high and in_full low, carrying in_sample and in_end_of_record.
// Result side is a queue read port: the oldest result sits on out_smoothed /
// out_final_output while out_empty is low and leaves on an edge with out_pop.
//
// Each output is centered on its sample: the result for sample k-2 appears
// after sample k. The first two and last two results of a record are zero;
// the end-of-record sample flushes up to three results, the last flagged by
// out_final_output.
//
// Throughput: one sample per cycle while in_full is low. A record end yields
// up to three results, set by the back end, which drains one result per cycle
// from the queue while the output register is empty or being popped. Path: a
// result passes the sum stage (loaded at the edge that takes its sample), then
// the reciprocal multiply stage, the command queue and the output register.
// The front stalls (in_full) only when the command queue plus the two
// in-flight pipeline stages would exceed QDEPTH; a stalled receiver thus
// backs up into the queue before in_full rises. Reset empties the pipeline,
// the queue and the output register and starts a new record.
module five_tap_weighted_smoothing_filter #(
  parameter int SAMPLE_BITS = tsmf_pkg::SAMPLE_BITS_DEF,
  parameter int QDEPTH      = tsmf_pkg::QDEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_end_of_record,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [SAMPLE_BITS-1:0] out_smoothed,
  output logic                   out_final_output
);
  import tsmf_pkg::*;

  localparam int CW = $clog2(QDEPTH + 1);

  logic                   q_wr, q_rd, q_empty;
  logic [SAMPLE_BITS-1:0] q_wr_val, q_rd_val;
  cmd_ctl_t               q_wr_ctl, q_rd_ctl;
  logic [CW-1:0]          q_count;

  // Front: window, record position, weighted sum and exact divide by 9.
  tsmf_front #(.SB(SAMPLE_BITS), .QD(QDEPTH)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_sample        (in_sample),
    .in_end_of_record (in_end_of_record),
    .q_count          (q_count),
    .cmd_wr           (q_wr),
    .cmd_val          (q_wr_val),
    .cmd_ctl          (q_wr_ctl)
  );

  // Decoupling queue: one entry per sample that yields any result.
  tsmf_queue #(.SB(SAMPLE_BITS), .QD(QDEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_val (q_wr_val),
    .wr_ctl (q_wr_ctl),
    .rd     (q_rd),
    .rd_val (q_rd_val),
    .rd_ctl (q_rd_ctl),
    .empty  (q_empty),
    .count  (q_count)
  );

  // Back: one result per cycle into the output register while it is empty or popped.
  tsmf_back #(.SB(SAMPLE_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_val            (q_rd_val),
    .q_ctl            (q_rd_ctl),
    .q_rd             (q_rd),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_smoothed     (out_smoothed),
    .out_final_output (out_final_output)
  );

  // The credit check must keep the queue from ever overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr |-> (q_count < CW'(QDEPTH)))
    else $error("command queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty)
    else $error("command queue read while empty");

  // With nothing queued, a popped result leaves the output empty.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && q_empty) |=> out_empty)
    else $error("result appeared without a queued command");

endmodule

@@ rtl/core/tsmf_front.sv @@
// Front end: window, classification, weighted sum and divide-by-9 pipeline.
module tsmf_front #(
  parameter int SB = tsmf_pkg::SAMPLE_BITS_DEF,
  parameter int QD = tsmf_pkg::QDEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [SB-1:0]          in_sample,
  input  logic                   in_end_of_record,
  input  logic [$clog2(QD+1)-1:0] q_count,
  output logic                   cmd_wr,
  output logic [SB-1:0]          cmd_val,
  output tsmf_pkg::cmd_ctl_t     cmd_ctl
);
  import tsmf_pkg::*;

  localparam int SW = SB + 4;          // weighted sum width, signed
  localparam int K  = SW;              // reciprocal scale
  localparam int CW = $clog2(QD + 1);
  localparam logic [K-1:0] RECIP = K'((64'd1 << K) / 64'd9);
  localparam logic [SW-1:0] NINE = SW'(9);

  logic                 accept;
  logic signed [SB-1:0] dly_r [4];
  logic [2:0]           seen_r, seen_nxt;
  cmd_ctl_t             cls_ctl;
  logic                 cls_filt;
  logic signed [SW-1:0] sum;

  logic                 v1_r, v2_r;
  cmd_ctl_t             ctl1_r, ctl2_r;
  logic                 filt1_r, filt2_r;
  logic signed [SW-1:0] sum1_r;
  logic                 neg2_r;
  logic [SW-1:0]        abs1, abs2_r;
  logic [2*K-1:0]       prod2_r;

  logic [SW-1:0]        q0, q9, rem, qa, qs;

  // Items in the two pipeline stages already own a queue slot.
  assign in_full = ((CW + 1)'(q_count) + (CW + 1)'(v1_r) + (CW + 1)'(v2_r))
                   >= (CW + 1)'(QD);
  assign accept  = in_push & ~in_full;

  // Classification on samples taken so far in this record.
  always_comb begin
    cls_filt    = seen_r[2];
    cls_ctl.eor = in_end_of_record;
    if (in_end_of_record) begin
      cls_ctl.cnt = (seen_r >= 3'd2) ? 2'd3 : (seen_r[1:0] + 2'd1);
    end else begin
      cls_ctl.cnt = (seen_r >= 3'd2) ? 2'd1 : 2'd0;
    end
    seen_nxt = in_end_of_record ? 3'd0 : (seen_r[2] ? seen_r : seen_r + 3'd1);
  end

  // Weights 1,2,3,2,1 with the newest sample on the x1 tap.
  always_comb begin
    sum = SW'(signed'(in_sample))
        + (SW'(dly_r[0]) <<< 1)
        + SW'(dly_r[1]) + (SW'(dly_r[1]) <<< 1)
        + (SW'(dly_r[2]) <<< 1)
        + SW'(dly_r[3]);
  end

  assign abs1 = sum1_r[SW-1] ? SW'(-sum1_r) : SW'(sum1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 3'd0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
    end else begin
      v1_r <= accept && (cls_ctl.cnt != 2'd0);
      v2_r <= v1_r;
      if (accept) begin
        seen_r <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dly_r[0] <= in_sample;
      dly_r[1] <= dly_r[0];
      dly_r[2] <= dly_r[1];
      dly_r[3] <= dly_r[2];
    end
    ctl1_r  <= cls_ctl;
    filt1_r <= cls_filt;
    sum1_r  <= sum;
    ctl2_r  <= ctl1_r;
    filt2_r <= filt1_r;
    neg2_r  <= sum1_r[SW-1];
    abs2_r  <= abs1;
    prod2_r <= abs1 * RECIP;
  end

  // Reciprocal quotient is low by at most one; one compare fixes it.
  always_comb begin
    q0  = prod2_r[2*K-1:K];
    q9  = q0 + (q0 << 3);
    rem = abs2_r - q9;
    qa  = (rem >= NINE) ? q0 + SW'(1) : q0;
    qs  = neg2_r ? SW'(-qa) : qa;
  end

  assign cmd_wr  = v2_r;
  assign cmd_ctl = ctl2_r;
  assign cmd_val = filt2_r ? qs[SB-1:0] : '0;

endmodule

@@ rtl/core/tsmf_queue.sv @@
// Command queue between the front and back ends.
module tsmf_queue #(
  parameter int SB = tsmf_pkg::SAMPLE_BITS_DEF,
  parameter int QD = tsmf_pkg::QDEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr,
  input  logic [SB-1:0]           wr_val,
  input  tsmf_pkg::cmd_ctl_t      wr_ctl,
  input  logic                    rd,
  output logic [SB-1:0]           rd_val,
  output tsmf_pkg::cmd_ctl_t      rd_ctl,
  output logic                    empty,
  output logic [$clog2(QD+1)-1:0] count
);
  import tsmf_pkg::*;

  localparam int AW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  logic [SB-1:0] val_r [QD];
  cmd_ctl_t      ctl_r [QD];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(QD - 1)) ? '0 : p + AW'(1);
  endfunction

  assign empty  = (cnt_r == '0);
  assign count  = cnt_r;
  assign rd_val = val_r[rp_r];
  assign rd_ctl = ctl_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= bump(wp_r);
      if (rd) rp_r <= bump(rp_r);
      cnt_r <= cnt_r + CW'(wr) - CW'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      val_r[wp_r] <= wr_val;
      ctl_r[wp_r] <= wr_ctl;
    end
  end

endmodule

@@ rtl/core/tsmf_back.sv @@
// Back end: expands each command into its results and holds the output register.
module tsmf_back #(
  parameter int SB = tsmf_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  logic [SB-1:0]      q_val,
  input  tsmf_pkg::cmd_ctl_t q_ctl,
  output logic               q_rd,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [SB-1:0]      out_smoothed,
  output logic               out_final_output
);
  import tsmf_pkg::*;

  logic          ov_r;
  logic [SB-1:0] val_r;
  logic          fin_r;
  logic [1:0]    idx_r;
  logic          load, last;

  assign load = !q_empty && (!ov_r || out_pop);
  assign last = (idx_r == q_ctl.cnt - 2'd1);
  assign q_rd = load && last;

  assign out_empty        = !ov_r;
  assign out_smoothed     = val_r;
  assign out_final_output = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      idx_r <= 2'd0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= last ? 2'd0 : idx_r + 2'd1;
      end else if (out_pop) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Only the first result of a command carries the value; the rest are zero.
  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= (idx_r == 2'd0) ? q_val : '0;
      fin_r <= q_ctl.eor && last;
    end
  end

endmodule
